// ===== rtl/ntc_pkg.sv =====
package ntc_pkg;

  // Type codes shared by the source and target configuration registers.
  localparam logic [3:0] TYPE_I8   = 4'd0;
  localparam logic [3:0] TYPE_U8   = 4'd1;
  localparam logic [3:0] TYPE_I16  = 4'd2;
  localparam logic [3:0] TYPE_U16  = 4'd3;
  localparam logic [3:0] TYPE_I32  = 4'd4;
  localparam logic [3:0] TYPE_U32  = 4'd5;
  localparam logic [3:0] TYPE_I64  = 4'd6;
  localparam logic [3:0] TYPE_U64  = 4'd7;
  localparam logic [3:0] TYPE_F32  = 4'd8;
  localparam logic [3:0] TYPE_F64  = 4'd9;
  localparam logic [3:0] TYPE_C64  = 4'd10;
  localparam logic [3:0] TYPE_C128 = 4'd11;
  localparam logic [3:0] TYPE_NULL = 4'd12;

  // Configuration register indexes.
  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_TARGET = 1'b1;

  // Value classes after decode.
  localparam logic [1:0] CLS_ZERO = 2'd0;
  localparam logic [1:0] CLS_FIN  = 2'd1;
  localparam logic [1:0] CLS_INF  = 2'd2;
  localparam logic [1:0] CLS_NAN  = 2'd3;

  // Conversion setup derived from the two type registers.
  typedef struct packed {
    logic       src_sgn;
    logic [1:0] src_wcode;
    logic       src_dbl;
    logic       tgt_int;
    logic       tgt_sgn;
    logic [1:0] tgt_wcode;
    logic       tgt_dbl;
    logic       same_prec;
  } ntc_cfg_t;

endpackage

// ===== rtl/numeric_type_converter_top.sv =====
// Numeric type converter: converts one element per request between signed and
// unsigned 8/16/32/64-bit integers, single and double floats, and single and
// double complex values, selected by the source and target type registers
// (write them only while the block is idle). A request enters every clock unless the
// output stalls the pipeline; the work is split over the five stages
// of each lane (decode, leading zero count, normalize, align, round and pack).
// A source or target type of null, or an unused code, drops the request with no result.
// Float to integer truncates and saturates, flagging NaN and overflow in tuser.
module numeric_type_converter_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [3:0]   cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // value_re [63:0], value_im [127:64]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // result_re [63:0], result_im [127:64]
  output logic         m_tuser,   // range_flag
  output logic         m_tlast
);

  logic [3:0] source_type, target_type;
  logic [4:0] valid, en;
  logic [4:0] last;
  logic types_ok, src_int, src_cplx, tgt_cplx;
  ntc_pkg::ntc_cfg_t cfg;
  logic [63:0] re_res, im_res;
  logic re_flag, im_flag;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_type <= ntc_pkg::TYPE_I8;
      target_type <= ntc_pkg::TYPE_I8;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ntc_pkg::CFG_SOURCE: source_type <= cfg_wdata;
        ntc_pkg::CFG_TARGET: target_type <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Conversion setup decoded from the registers.
  always_comb begin
    src_int = source_type < ntc_pkg::TYPE_F32;
    src_cplx = source_type >= ntc_pkg::TYPE_C64;
    tgt_cplx = target_type >= ntc_pkg::TYPE_C64;
    types_ok = (source_type < ntc_pkg::TYPE_NULL) && (target_type < ntc_pkg::TYPE_NULL);
    cfg.src_sgn = !source_type[0];
    cfg.src_wcode = source_type[2:1];
    cfg.src_dbl = (source_type == ntc_pkg::TYPE_F64) || (source_type == ntc_pkg::TYPE_C128);
    cfg.tgt_int = target_type < ntc_pkg::TYPE_F32;
    cfg.tgt_sgn = !target_type[0];
    cfg.tgt_wcode = target_type[2:1];
    cfg.tgt_dbl = (target_type == ntc_pkg::TYPE_F64) || (target_type == ntc_pkg::TYPE_C128);
    cfg.same_prec = cfg.src_dbl == cfg.tgt_dbl;
  end

  // Stage enables: a stage loads when it is empty or the next one moves.
  always_comb begin
    en[4] = !valid[4] || m_tready;
    for (int i = 3; i >= 0; i--) en[i] = !valid[i] || en[i + 1];
  end
  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= s_tvalid && types_ok;
      for (int i = 1; i < 5; i++) begin
        if (en[i]) valid[i] <= valid[i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) last[0] <= s_tlast;
    for (int i = 1; i < 5; i++) begin
      if (en[i]) last[i] <= last[i - 1];
    end
  end

  ntc_lane u_re (
    .clk(clk), .en(en), .cfg(cfg), .int_src(src_int),
    .raw(s_tdata[63:0]), .result(re_res), .flag(re_flag)
  );

  ntc_lane u_im (
    .clk(clk), .en(en), .cfg(cfg), .int_src(1'b0),
    .raw(s_tdata[127:64]), .result(im_res), .flag(im_flag)
  );

  // The imaginary lane's flag is never used, and its result only for a complex source and target.
  assign m_tvalid = valid[4];
  assign m_tdata = {(tgt_cplx && src_cplx) ? im_res : 64'd0, re_res};
  assign m_tuser = re_flag | (im_flag & 1'b0);
  assign m_tlast = last[4];

endmodule

// ===== rtl/ntc_lane.sv =====
module ntc_lane (
  input  logic              clk,
  input  logic [4:0]        en,
  input  ntc_pkg::ntc_cfg_t cfg,
  input  logic              int_src,
  input  logic [63:0]       raw,
  output logic [63:0]       result,
  output logic              flag
);

  typedef struct packed {
    logic [1:0]  cls;
    logic        neg;
    logic [51:0] nan;
    logic [63:0] pattern;
    logic [63:0] raw;
  } pass_t;

  pass_t p1, p2, p3, p4, p0;
  logic [63:0] mag1, mag2, mag0;
  logic signed [12:0] exp1, exp2, exp0;
  logic [5:0] lz2, lz_d;
  logic [63:0] m3, m_d;
  logic signed [12:0] e3, e_d;
  logic [63:0] q4, q_d, imag4, imag_d;
  logic rbit4, sticky4, over4, rbit_d, sticky_d, over_d;
  logic signed [12:0] bexp4, bexp_d;
  logic [63:0] result_d;
  logic flag_d;

  // Stage 1: decode the raw bits into class, sign, magnitude and exponent.
  always_comb begin
    logic [63:0] ext, imag;
    logic ineg;
    logic [51:0] frac;
    logic [10:0] ef;
    logic emax_hit;
    case (cfg.src_wcode)
      2'd0: ext = {{56{cfg.src_sgn & raw[7]}}, raw[7:0]};
      2'd1: ext = {{48{cfg.src_sgn & raw[15]}}, raw[15:0]};
      2'd2: ext = {{32{cfg.src_sgn & raw[31]}}, raw[31:0]};
      default: ext = raw;
    endcase
    ineg = cfg.src_sgn & ext[63];
    imag = ineg ? (64'd0 - ext) : ext;
    frac = cfg.src_dbl ? raw[51:0] : {29'd0, raw[22:0]};
    ef = cfg.src_dbl ? raw[62:52] : {3'd0, raw[30:23]};
    emax_hit = cfg.src_dbl ? (ef == 11'h7ff) : (ef == 11'h0ff);
    p0.raw = raw;
    p0.pattern = ext;
    p0.nan = cfg.src_dbl ? frac : {frac[22:0], 29'd0};
    if (int_src) begin
      p0.cls = (imag != 64'd0) ? ntc_pkg::CLS_FIN : ntc_pkg::CLS_ZERO;
      p0.neg = ineg;
      mag0 = imag;
      exp0 = 13'sd0;
    end else begin
      p0.neg = cfg.src_dbl ? raw[63] : raw[31];
      mag0 = 64'd0;
      exp0 = 13'sd0;
      if (emax_hit) begin
        p0.cls = (frac != 52'd0) ? ntc_pkg::CLS_NAN : ntc_pkg::CLS_INF;
      end else if (ef == 11'd0) begin
        p0.cls = (frac != 52'd0) ? ntc_pkg::CLS_FIN : ntc_pkg::CLS_ZERO;
        mag0 = {12'd0, frac};
        exp0 = cfg.src_dbl ? -13'sd1074 : -13'sd149;
      end else begin
        p0.cls = ntc_pkg::CLS_FIN;
        mag0 = cfg.src_dbl ? {11'd0, 1'b1, frac} : {40'd0, 1'b1, frac[22:0]};
        exp0 = $signed({2'b00, ef}) - (cfg.src_dbl ? 13'sd1075 : 13'sd150);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1 <= p0;
      mag1 <= mag0;
      exp1 <= exp0;
    end
  end

  // Stage 2: leading zero count of the magnitude.
  always_comb begin
    lz_d = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag1[i]) lz_d = 6'(63 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p2 <= p1;
      mag2 <= mag1;
      exp2 <= exp1;
      lz2 <= lz_d;
    end
  end

  // Stage 3: normalize so the top set bit sits at bit 63.
  assign m_d = mag2 << lz2;
  assign e_d = exp2 + 13'sd63 - $signed({7'd0, lz2});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p3 <= p2;
      m3 <= m_d;
      e3 <= e_d;
    end
  end

  // Stage 4: align for the float target and for the integer target.
  always_comb begin
    logic signed [12:0] sfull;
    logic [6:0] s;
    logic [127:0] x;
    bexp_d = e3 + (cfg.tgt_dbl ? 13'sd1023 : 13'sd127);
    sfull = cfg.tgt_dbl ? 13'sd11 : 13'sd40;
    if (bexp_d < 13'sd1) sfull = sfull + 13'sd1 - bexp_d;
    s = (sfull > 13'sd127) ? 7'd127 : sfull[6:0];
    x = {m3, 64'd0} >> s;
    q_d = x[127:64];
    rbit_d = x[63];
    sticky_d = |x[62:0];
    over_d = (p3.cls == ntc_pkg::CLS_INF) ||
             ((p3.cls == ntc_pkg::CLS_FIN) && (e3 > 13'sd63));
    if (e3 < 13'sd0 || e3 > 13'sd63) imag_d = 64'd0;
    else imag_d = m3 >> (6'd63 - e3[5:0]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p4 <= p3;
      q4 <= q_d;
      rbit4 <= rbit_d;
      sticky4 <= sticky_d;
      bexp4 <= bexp_d;
      imag4 <= imag_d;
      over4 <= over_d;
    end
  end

  // Stage 5: round and pack the float, or saturate or wrap the integer.
  always_comb begin
    logic [63:0] wmask, limpos, limneg, mag, qr, fres, emax_f, sbit;
    logic signed [12:0] be;
    logic carry;
    case (cfg.tgt_wcode)
      2'd0: wmask = 64'hff;
      2'd1: wmask = 64'hffff;
      2'd2: wmask = 64'hffff_ffff;
      default: wmask = '1;
    endcase
    limpos = cfg.tgt_sgn ? (wmask >> 1) : wmask;
    limneg = cfg.tgt_sgn ? ((wmask >> 1) + 64'd1) : 64'd0;
    flag_d = 1'b0;
    mag = imag4;
    if (!p4.neg && (over4 || mag > limpos)) begin
      mag = limpos;
      flag_d = 1'b1;
    end
    if (p4.neg && (over4 || mag > limneg)) begin
      mag = limneg;
      flag_d = 1'b1;
    end
    if (p4.cls == ntc_pkg::CLS_NAN) begin
      mag = 64'd0;
      flag_d = 1'b1;
    end

    // Float encode.
    sbit = cfg.tgt_dbl ? {p4.neg, 63'd0} : {32'd0, p4.neg, 31'd0};
    emax_f = cfg.tgt_dbl ? {1'b0, 11'h7ff, 52'd0} : {33'd0, 8'hff, 23'd0};
    qr = q4 + {63'd0, rbit4 & (sticky4 | q4[0])};
    be = bexp4;
    carry = 1'b0;
    case (p4.cls)
      ntc_pkg::CLS_ZERO: fres = sbit;
      ntc_pkg::CLS_INF:  fres = sbit | emax_f;
      ntc_pkg::CLS_NAN:  fres = cfg.tgt_dbl ?
                           (sbit | emax_f | {12'd0, p4.nan} | (64'd1 << 51)) :
                           (sbit | emax_f | {41'd0, p4.nan[51:29]} | (64'd1 << 22));
      default: begin
        if (be >= 13'sd1) begin
          carry = cfg.tgt_dbl ? qr[53] : qr[24];
          if (carry) begin
            qr = qr >> 1;
            be = be + 13'sd1;
          end
          if (be >= (cfg.tgt_dbl ? 13'sd2047 : 13'sd255)) fres = sbit | emax_f;
          else if (cfg.tgt_dbl) fres = {p4.neg, be[10:0], qr[51:0]};
          else fres = {32'd0, p4.neg, be[7:0], qr[22:0]};
        end else begin
          fres = cfg.tgt_dbl ? (sbit | {1'b0, qr[62:0]}) : (sbit | {33'd0, qr[30:0]});
        end
      end
    endcase

    if (cfg.tgt_int) begin
      if (int_src) begin
        result_d = p4.pattern & wmask;
        flag_d = 1'b0;
      end else begin
        result_d = (p4.neg ? (64'd0 - mag) : mag) & wmask;
      end
    end else begin
      flag_d = 1'b0;
      if (!int_src && cfg.same_prec) begin
        result_d = cfg.tgt_dbl ? p4.raw : {32'd0, p4.raw[31:0]};
      end else begin
        result_d = fres;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      result <= result_d;
      flag <= flag_d;
    end
  end

endmodule

// ===== rtl/ntc_checker.sv =====
module ntc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic         m_tuser,
  input logic         m_tlast
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // The input side only stalls when the pipeline is full up to the output.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled with room in the pipeline");

endmodule

bind numeric_type_converter_top ntc_checker u_ntc_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

// ===== dv/tb_numeric_type_converter_top.sv =====
module tb_numeric_type_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1550;

  typedef struct {
    logic [1:0]  cls;
    bit          neg;
    logic [63:0] mag;
    int          ex;
    logic [63:0] nanf;
  } num_t;

  typedef struct {
    logic [63:0] re;
    logic [63:0] im;
    bit          last;
  } req_t;

  typedef struct {
    logic [63:0] re;
    logic [63:0] im;
    bit          flag;
    bit          last;
  } conv_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = 1'b0;
  logic [3:0]   cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  req_t        pending_req[$];
  conv_t       expected_conv[$];
  logic [3:0]  src_type = ntc_pkg::TYPE_I8;
  logic [3:0]  tgt_type = ntc_pkg::TYPE_I8;
  bit          no_idle = 1'b0;
  int          fail_count = 0;
  int          cycle_count = 0;

  numeric_type_converter_top uut (.*);

  always #2 clk = ~clk;

  function automatic logic [63:0] width_mask(int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  // Shift right with round to nearest even.
  function automatic logic [63:0] round_shift(logic [63:0] m, int s);
    logic [63:0] q, rem, half;
    if (s <= 0) return m;
    if (s > 64) return 0;
    if (s == 64) return (m[63] && (|m[62:0])) ? 64'd1 : 64'd0;
    q = m >> s;
    rem = m & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  function automatic num_t decode_int(logic [63:0] raw, int w, bit sgn,
                                      output logic [63:0] pattern);
    num_t r;
    logic [63:0] mk, v;
    mk = width_mask(w);
    v = raw & mk;
    if (sgn && w < 64 && v[w-1]) v = v | ~mk;
    pattern = v;
    r.neg = sgn && v[63];
    r.mag = r.neg ? -v : v;
    r.ex = 0;
    r.nanf = 0;
    r.cls = (r.mag != 0) ? ntc_pkg::CLS_FIN : ntc_pkg::CLS_ZERO;
    return r;
  endfunction

  function automatic num_t decode_float(logic [63:0] raw, int fb, int eb);
    num_t r;
    int bias;
    logic [63:0] emax, frac, ef;
    bias = (1 << (eb - 1)) - 1;
    emax = (64'd1 << eb) - 64'd1;
    frac = raw & width_mask(fb);
    ef = (raw >> fb) & emax;
    r.neg = raw[fb + eb];
    r.mag = 0;
    r.ex = 0;
    r.nanf = 0;
    if (ef == emax) begin
      r.cls = (frac != 0) ? ntc_pkg::CLS_NAN : ntc_pkg::CLS_INF;
      r.nanf = frac << (64 - fb);
    end else if (ef == 0) begin
      r.cls = (frac != 0) ? ntc_pkg::CLS_FIN : ntc_pkg::CLS_ZERO;
      r.mag = frac;
      r.ex = 1 - bias - fb;
    end else begin
      r.cls = ntc_pkg::CLS_FIN;
      r.mag = frac | (64'd1 << fb);
      r.ex = int'(ef) - bias - fb;
    end
    return r;
  endfunction

  function automatic logic [63:0] encode_float(num_t a, int fb, int eb);
    int bias, lz, bexp, p;
    logic [63:0] emax, sbit, m, q;
    bias = (1 << (eb - 1)) - 1;
    emax = (64'd1 << eb) - 64'd1;
    sbit = a.neg ? (64'd1 << (fb + eb)) : 64'd0;
    p = fb + 1;
    lz = 0;
    if (a.cls == ntc_pkg::CLS_ZERO) return sbit;
    if (a.cls == ntc_pkg::CLS_INF) return sbit | (emax << fb);
    if (a.cls == ntc_pkg::CLS_NAN)
      return sbit | (emax << fb) | (a.nanf >> (64 - fb)) | (64'd1 << (fb - 1));
    m = a.mag;
    while (!m[63]) begin
      m = m << 1;
      lz++;
    end
    bexp = a.ex + 63 - lz + bias;
    if (bexp >= 1) begin
      q = round_shift(m, 64 - p);
      if ((q >> p) != 0) begin
        q = q >> 1;
        bexp++;
      end
      if (bexp >= int'(emax)) return sbit | (emax << fb);
      return sbit | (64'(bexp) << fb) | (q & width_mask(fb));
    end
    q = round_shift(m, 64 - p + 1 - bexp);
    return sbit | q;
  endfunction

  // Truncate toward zero, saturating out-of-range values with a flag.
  function automatic logic [63:0] float_to_int(num_t a, int w, bit sgn, output bit flag);
    logic [63:0] mag, limpos, limneg;
    bit over;
    mag = 0;
    over = 0;
    flag = 0;
    if (a.cls == ntc_pkg::CLS_NAN) begin
      flag = 1;
      return 0;
    end
    if (a.cls == ntc_pkg::CLS_INF) over = 1;
    else if (a.cls == ntc_pkg::CLS_FIN) begin
      if (a.ex >= 0) begin
        if (a.ex >= 64 || a.mag > ({64{1'b1}} >> a.ex)) over = 1;
        else mag = a.mag << a.ex;
      end else if (a.ex > -64) begin
        mag = a.mag >> (-a.ex);
      end
    end
    limpos = sgn ? width_mask(w - 1) : width_mask(w);
    limneg = sgn ? (64'd1 << (w - 1)) : 64'd0;
    if (!a.neg && (over || mag > limpos)) begin
      mag = limpos;
      flag = 1;
    end
    if (a.neg && (over || mag > limneg)) begin
      mag = limneg;
      flag = 1;
    end
    return (a.neg ? -mag : mag) & width_mask(w);
  endfunction

  // Expected conversion of one element under the current type registers.
  function automatic bit convert_elem(req_t r, output conv_t c);
    bit src_int, src_cplx, src_dbl, tgt_dbl;
    int sfb, seb, tfb, teb, tw;
    num_t re, im;
    logic [63:0] pattern, tmask;
    bit flag;
    c = '{default: 0};
    flag = 0;
    pattern = 0;
    if (src_type >= ntc_pkg::TYPE_NULL || tgt_type >= ntc_pkg::TYPE_NULL) return 0;
    src_int = src_type < ntc_pkg::TYPE_F32;
    src_cplx = src_type >= ntc_pkg::TYPE_C64;
    src_dbl = (src_type == ntc_pkg::TYPE_F64 || src_type == ntc_pkg::TYPE_C128);
    sfb = src_dbl ? 52 : 23;
    seb = src_dbl ? 11 : 8;
    if (src_int) re = decode_int(r.re, 8 << (src_type >> 1), !src_type[0], pattern);
    else re = decode_float(r.re, sfb, seb);
    im = '{cls: ntc_pkg::CLS_ZERO, neg: 0, mag: 0, ex: 0, nanf: 0};
    if (src_cplx) im = decode_float(r.im, sfb, seb);
    if (tgt_type < ntc_pkg::TYPE_F32) begin
      tw = 8 << (tgt_type >> 1);
      if (src_int) c.re = pattern & width_mask(tw);
      else c.re = float_to_int(re, tw, !tgt_type[0], flag);
    end else begin
      tgt_dbl = (tgt_type == ntc_pkg::TYPE_F64 || tgt_type == ntc_pkg::TYPE_C128);
      tfb = tgt_dbl ? 52 : 23;
      teb = tgt_dbl ? 11 : 8;
      tmask = width_mask(tfb + teb + 1);
      if (!src_int && src_dbl == tgt_dbl) c.re = r.re & tmask;
      else c.re = encode_float(re, tfb, teb);
      if (tgt_type >= ntc_pkg::TYPE_C64 && src_cplx) begin
        if (src_dbl == tgt_dbl) c.im = r.im & tmask;
        else c.im = encode_float(im, tfb, teb);
      end
    end
    c.flag = flag;
    c.last = r.last;
    return 1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Float patterns biased toward integer limits, rounding ties and specials.
  function automatic logic [63:0] gen_float(bit dbl);
    int fb, eb, bias, emax;
    logic [63:0] frac, ef, raw;
    fb = dbl ? 52 : 23;
    eb = dbl ? 11 : 8;
    bias = (1 << (eb - 1)) - 1;
    emax = (1 << eb) - 1;
    frac = rand64() & width_mask(fb);
    case ($urandom_range(0, 9))
      0: begin
        ef = 64'd0;
        frac = 64'd0;
      end
      1: begin
        ef = 64'(emax);
        frac = 64'd0;
      end
      2: begin
        ef = 64'(emax);
        if (frac == 0) frac = 64'd1 << $urandom_range(0, fb - 1);
      end
      3: ef = 64'd0;
      4, 5, 6: ef = 64'(bias - 3 + int'($urandom_range(0, 70)));
      7: begin
        ef = dbl ? 64'(bias - 160 + int'($urandom_range(0, 300)))
                 : 64'($urandom_range(1, emax - 1));
        if (dbl && $urandom_range(0, 1)) frac = (frac & ~width_mask(29)) | (64'd1 << 28);
      end
      8: ef = 64'($urandom_range(1, emax - 1));
      default: ef = rand64();
    endcase
    raw = ((ef & 64'(emax)) << fb) | frac | (64'($urandom_range(0, 1)) << (fb + eb));
    if (!dbl) raw[63:32] = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    return raw;
  endfunction

  function automatic logic [63:0] gen_int(int w);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = 64'd1 << (w - 1);
      1: v = width_mask(w - 1);
      2: v = width_mask(w);
      3: v = 64'(0);
      default: v = rand64();
    endcase
    if ($urandom_range(0, 1)) v = v | (rand64() & ~width_mask(w));
    return v;
  endfunction

  function automatic req_t gen_req(logic [3:0] src);
    req_t r;
    r.im = rand64();
    r.last = ($urandom_range(0, 7) == 0);
    if (src < ntc_pkg::TYPE_F32) r.re = gen_int(8 << (src >> 1));
    else if (src < ntc_pkg::TYPE_NULL) begin
      r.re = gen_float(src == ntc_pkg::TYPE_F64 || src == ntc_pkg::TYPE_C128);
      if (src >= ntc_pkg::TYPE_C64) r.im = gen_float(src == ntc_pkg::TYPE_C128);
    end else r.re = rand64();
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_req.size() != 0 || expected_conv.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Reprogram both type registers once the block has drained.
  task automatic set_types(logic [3:0] src, logic [3:0] tgt);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= ntc_pkg::CFG_SOURCE;
    cfg_wdata <= src;
    @(posedge clk);
    cfg_addr <= ntc_pkg::CFG_TARGET;
    cfg_wdata <= tgt;
    @(posedge clk);
    cfg_we <= 1'b0;
    src_type = src;
    tgt_type = tgt;
  endtask

  task automatic push_req(logic [63:0] re, logic [63:0] im);
    pending_req.push_back('{re: re, im: im, last: 1'($urandom_range(0, 1))});
  endtask

  // Sender: holds a request until it is taken, idles at random.
  always @(posedge clk) begin
    conv_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (convert_elem(pending_req[0], c)) expected_conv.push_back(c);
        void'(pending_req.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (pending_req.size() != 0 && (no_idle || $urandom_range(0, 99) >= 15)) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending_req[0].im, pending_req[0].re};
        s_tlast <= pending_req[0].last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random backpressure and field-by-field comparison.
  always @(posedge clk) begin
    conv_t c;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle || $urandom_range(0, 99) >= 15;
      if (m_tvalid && m_tready) begin
        if (expected_conv.size() == 0) begin
          $error("unexpected result re=%h im=%h", m_tdata[63:0], m_tdata[127:64]);
          fail_count++;
        end else begin
          c = expected_conv.pop_front();
          if (m_tdata[63:0] !== c.re) begin
            $error("result_re expected %h actual %h", c.re, m_tdata[63:0]);
            fail_count++;
          end
          if (m_tdata[127:64] !== c.im) begin
            $error("result_im expected %h actual %h", c.im, m_tdata[127:64]);
            fail_count++;
          end
          if (m_tuser !== c.flag) begin
            $error("range_flag expected %b actual %b", c.flag, m_tuser);
            fail_count++;
          end
          if (m_tlast !== c.last) begin
            $error("last_out expected %b actual %b", c.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_numeric_type_converter_top failed");
      $finish;
    end
  end

  initial begin
    int counted;
    int n;
    logic [3:0] src, tgt;
    counted = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: integer extension, limits, specials, precision changes.
    set_types(ntc_pkg::TYPE_I8, ntc_pkg::TYPE_I64);
    push_req(64'h80, 0);
    push_req(64'h7f, 0);
    push_req('1, '1);
    push_req(0, 0);
    set_types(ntc_pkg::TYPE_U64, ntc_pkg::TYPE_F32);
    push_req('1, 0);
    push_req(64'h0000_0000_0100_0001, 0);
    set_types(ntc_pkg::TYPE_F64, ntc_pkg::TYPE_I32);
    push_req(64'h7ff8_0000_0000_0001, 0);
    push_req(64'h7ff0_0000_0000_0000, 0);
    push_req(64'hfff0_0000_0000_0000, 0);
    push_req(64'hbfe0_0000_0000_0000, 0);
    push_req(64'hbff8_0000_0000_0000, 0);
    push_req(64'h41e0_0000_0000_0000, 0);
    set_types(ntc_pkg::TYPE_F64, ntc_pkg::TYPE_U16);
    push_req(64'hbff0_0000_0000_0000, 0);
    push_req(64'hbfec_cccc_cccc_cccd, 0);
    set_types(ntc_pkg::TYPE_F64, ntc_pkg::TYPE_F32);
    push_req(64'h7e37_e43c_8800_759c, 0);
    push_req(64'h3680_0000_0000_0000, 0);
    push_req(64'h7ff0_0000_0000_0001, 0);
    set_types(ntc_pkg::TYPE_C64, ntc_pkg::TYPE_C128);
    push_req(64'h8000_0000, 64'hffc0_0001);
    set_types(ntc_pkg::TYPE_C128, ntc_pkg::TYPE_F64);
    push_req(64'hfff8_0000_0000_0abc, 64'h3ff0_0000_0000_0000);
    set_types(ntc_pkg::TYPE_F32, ntc_pkg::TYPE_C64);
    push_req(64'hdead_beef_3f80_0000, '1);
    set_types(ntc_pkg::TYPE_C128, ntc_pkg::TYPE_NULL);
    push_req('1, '1);
    set_types(4'd15, 4'd15);
    push_req('1, '1);
    set_types(ntc_pkg::TYPE_I8, ntc_pkg::TYPE_I8);
    push_req(64'h1234_5678_9abc_def0, 0);

    // Random phases, one type pair each.
    while (counted < RANDOM_ITEMS) begin
      src = ($urandom_range(0, 14) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
      tgt = ($urandom_range(0, 14) == 0) ? 4'($urandom_range(12, 15))
                                         : 4'($urandom_range(0, 11));
      set_types(src, tgt);
      no_idle = (counted >= 600 && counted < 800);
      n = $urandom_range(5, 40);
      repeat (n) pending_req.push_back(gen_req(src));
      if (src < ntc_pkg::TYPE_NULL && tgt < ntc_pkg::TYPE_NULL) counted += n;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_numeric_type_converter_top passed");
    end else begin
      $display("tb_numeric_type_converter_top failed");
    end
    $finish;
  end

endmodule
